@@ rtl/icy_pkg.sv @@
// shared types and constants for the icy metadata demultiplexer
`default_nettype none

package icy_pkg;

  localparam int INTERVAL_W  = 20;
  localparam int MAX_BLK_W   = 8;
  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 3;
  localparam int BLOCK_BYTES = 16;
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int META_LEFT_W = MAX_BLK_W + BLOCK_SHIFT;
  localparam int TITLE_MAX   = 127;
  localparam int TITLE_W     = $clog2(TITLE_MAX + 1);

  localparam logic [BYTE_W-1:0]    QUOTE_CHAR    = 8'h27;
  localparam logic [MAX_BLK_W-1:0] MAX_BLK_RESET = 8'd32;

  // register indexes, taken from paddr[2]
  localparam logic REG_META_INTERVAL = 1'b0;
  localparam logic REG_MAX_BLOCKS    = 1'b1;

  typedef enum logic [1:0] {
    PH_AUDIO,
    PH_LENGTH,
    PH_META
  } phase_t;

  typedef enum logic [1:0] {
    QS_BEFORE,
    QS_INSIDE,
    QS_AFTER
  } quote_t;

  typedef enum logic [KIND_W-1:0] {
    K_AUDIO  = 3'd0,
    K_LENGTH = 3'd1,
    K_META   = 3'd2,
    K_TITLE  = 3'd3,
    K_REJECT = 3'd4
  } kind_t;

  typedef struct packed {
    logic [INTERVAL_W-1:0] meta_interval;
    logic [MAX_BLK_W-1:0]  max_meta_blocks;
    logic                  interval_wr;
    logic [INTERVAL_W-1:0] interval_wdata;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/icy_if.sv @@
// stream byte and result channels of the demultiplexer
`default_nettype none

interface icy_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface icy_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] out_kind;
  logic [7:0] out_byte;
  logic       meta_end;

  modport source (output valid, output out_kind, output out_byte, output meta_end, input ready);
  modport sink (input valid, input out_kind, input out_byte, input meta_end, output ready);
endinterface

`default_nettype wire

@@ rtl/icy_metadata_demux.sv @@
// icy metadata demultiplexer top level: register port and parser
// latency: a result is registered, valid in the cycle after its stream byte transfer
// throughput: one byte per cycle, bounded only by the single result register
// a stalled result keeps input open only while the result register is being taken
// reset (rst, synchronous): audio phase, interval 0, max blocks 32, no result pending
`default_nettype none

module icy_metadata_demux
  import icy_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  icy_byte_if.sink         stream,
  icy_result_if.source     result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [INTERVAL_W-1:0] meta_interval;
  logic [MAX_BLK_W-1:0]  max_meta_blocks;
  logic                  wr;
  cfg_t                  cfg;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_interval   <= '0;
      max_meta_blocks <= MAX_BLK_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        REG_META_INTERVAL: meta_interval   <= pwdata[INTERVAL_W-1:0];
        REG_MAX_BLOCKS:    max_meta_blocks <= pwdata[MAX_BLK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_META_INTERVAL: prdata = {{(32-INTERVAL_W){1'b0}}, meta_interval};
      REG_MAX_BLOCKS:    prdata = {{(32-MAX_BLK_W){1'b0}}, max_meta_blocks};
      default:           prdata = '0;
    endcase
  end

  assign cfg.meta_interval   = meta_interval;
  assign cfg.max_meta_blocks = max_meta_blocks;
  assign cfg.interval_wr     = wr && (paddr[2] == REG_META_INTERVAL);
  assign cfg.interval_wdata  = pwdata[INTERVAL_W-1:0];

  icy_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .stream (stream),
    .result (result)
  );

endmodule

`default_nettype wire

@@ rtl/icy_core.sv @@
// stream parser: audio/length/metadata phases, title extraction, result register
`default_nettype none

module icy_core
  import icy_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    cfg,
  icy_byte_if.sink     stream,
  icy_result_if.source result
);

  phase_t                 phase, phase_next;
  quote_t                 quote_state, quote_state_next;
  logic [INTERVAL_W-1:0]  audio_left, audio_left_next;
  logic [META_LEFT_W-1:0] meta_left, meta_left_next;
  logic [TITLE_W-1:0]     title_count, title_count_next;

  kind_t                  kind;
  logic                   end_flag;
  logic                   accept;
  logic [BYTE_W-1:0]      b;

  logic                   out_valid;
  kind_t                  out_kind;
  logic [BYTE_W-1:0]      out_byte;
  logic                   meta_end;

  // result register frees up whenever it is empty or being taken
  assign stream.ready = !out_valid || result.ready;
  assign accept       = stream.valid && stream.ready;
  assign b            = stream.stream_byte;

  always_comb begin
    phase_next       = phase;
    quote_state_next = quote_state;
    audio_left_next  = audio_left;
    meta_left_next   = meta_left;
    title_count_next = title_count;
    kind             = K_AUDIO;
    end_flag         = 1'b0;

    if (cfg.interval_wr) begin
      phase_next      = PH_AUDIO;
      audio_left_next = cfg.interval_wdata;
      meta_left_next  = '0;
    end else if (accept && (cfg.meta_interval != '0)) begin
      unique case (phase)
        PH_LENGTH: begin
          if (b == '0) begin
            kind            = K_LENGTH;
            end_flag        = 1'b1;
            phase_next      = PH_AUDIO;
            audio_left_next = cfg.meta_interval;
            meta_left_next  = '0;
          end else if (b > cfg.max_meta_blocks) begin
            kind            = K_REJECT;
            end_flag        = 1'b1;
            phase_next      = PH_AUDIO;
            audio_left_next = cfg.meta_interval;
            meta_left_next  = '0;
          end else begin
            kind             = K_LENGTH;
            meta_left_next   = {b, {BLOCK_SHIFT{1'b0}}};
            quote_state_next = QS_BEFORE;
            title_count_next = '0;
            phase_next       = PH_META;
          end
        end
        PH_META: begin
          kind = K_META;
          unique case (quote_state)
            QS_BEFORE: begin
              if (b == QUOTE_CHAR) quote_state_next = QS_INSIDE;
            end
            QS_INSIDE: begin
              if (b == QUOTE_CHAR) begin
                quote_state_next = QS_AFTER;
              end else if (title_count < TITLE_W'(TITLE_MAX)) begin
                kind             = K_TITLE;
                title_count_next = title_count + 1'b1;
              end
            end
            default: ;
          endcase
          if (meta_left <= META_LEFT_W'(1)) begin
            end_flag        = 1'b1;
            phase_next      = PH_AUDIO;
            audio_left_next = cfg.meta_interval;
            meta_left_next  = '0;
          end else begin
            meta_left_next = meta_left - 1'b1;
          end
        end
        default: begin
          kind = K_AUDIO;
          if (audio_left <= INTERVAL_W'(1)) begin
            audio_left_next = '0;
            phase_next      = PH_LENGTH;
          end else begin
            audio_left_next = audio_left - 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_AUDIO;
      quote_state <= QS_BEFORE;
      audio_left  <= '0;
      meta_left   <= '0;
      title_count <= '0;
    end else begin
      phase       <= phase_next;
      quote_state <= quote_state_next;
      audio_left  <= audio_left_next;
      meta_left   <= meta_left_next;
      title_count <= title_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_kind <= kind;
      out_byte <= b;
      meta_end <= end_flag;
    end
  end

  assign result.valid    = out_valid;
  assign result.out_kind = out_kind;
  assign result.out_byte = out_byte;
  assign result.meta_end = meta_end;

  // a metadata slot in progress always has bytes left
  a_meta_left: assert property (@(posedge clk) disable iff (rst)
    phase == PH_META |-> meta_left != '0)
    else $error("metadata phase with empty byte count");

  // slot end only reported for length, reject or metadata bytes
  a_end_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && meta_end |-> out_kind != K_AUDIO)
    else $error("audio byte marked as slot end");

  // with metadata disabled every transfer is audio
  a_no_meta: assert property (@(posedge clk) disable iff (rst)
    accept && cfg.meta_interval == '0 |=> out_valid && out_kind == K_AUDIO && !meta_end)
    else $error("non-audio result with metadata disabled");

  // a pending result is not dropped while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |=> out_valid && $stable(out_byte))
    else $error("stalled result lost");

endmodule

`default_nettype wire
